@@ rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// shared widths, command codes and status codes of the task scheduler
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CMD_W       = 3;
    localparam int ID_W        = 4;
    localparam int ADDR_W      = 16;
    localparam int STAT_W      = 2;
    localparam int NUM_SLOTS   = 16;
    localparam int QUEUE_LEN_DEF = 16;

    // stream word widths, whole bytes
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELINQ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd3;

endpackage

@@ rtl/cts_ram.sv @@
// ----------------------------------------------------------------------------
// cts_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cooperative_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// cooperative_task_scheduler: task table plus a shared normal/priority ready ring
// each command passes an accept and an execute state; dispatch adds a task table
// read state after the ring read; one command in flight
// reset (synchronous, active low) frees all slots and empties the ring at once
// ----------------------------------------------------------------------------
module cooperative_task_scheduler #(
    parameter int QUEUE_LENGTH = cts_pkg::QUEUE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command word: command, task_id, priority_req, address
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [cts_pkg::S_TDATA_W-1:0] i_s_tdata,
    // result word: status, result_task_id, result_address, zero fill
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [cts_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_wen,
    input  logic                          i_cfg_wdata
);

    localparam int PW = $clog2(QUEUE_LENGTH);
    localparam int CW = $clog2(QUEUE_LENGTH + 1);
    localparam int SW = CW + 1;
    localparam int TableSlots = (QUEUE_LENGTH < cts_pkg::NUM_SLOTS) ?
                                QUEUE_LENGTH : cts_pkg::NUM_SLOTS;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_TBL} t_state;

    t_state                        r_state, n_state;
    logic [cts_pkg::CMD_W-1:0]     r_cmd;
    logic [cts_pkg::ID_W-1:0]      r_tid;
    logic                          r_preq;
    logic [cts_pkg::ADDR_W-1:0]    r_addr;
    logic                          r_prio_en;
    logic [cts_pkg::NUM_SLOTS-1:0] r_busy, n_busy;
    logic [PW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_total, n_total;
    logic [CW-1:0]                 r_prio, n_prio;
    logic [cts_pkg::ID_W-1:0]      r_run, n_run;
    logic                          r_o_valid, n_o_valid;
    logic [cts_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic [cts_pkg::ID_W-1:0]      r_o_id, n_o_id;
    logic [cts_pkg::ADDR_W-1:0]    r_o_addr, n_o_addr;

    logic                          w_acc;
    logic                          w_out_free;
    logic                          w_full;
    logic [SW-1:0]                 w_dsum, w_dpos, w_psum, w_ppos, w_nsum, w_npos;
    logic                          w_free_found;
    logic [cts_pkg::ID_W-1:0]      w_free_id;
    logic                          w_tw_en;
    logic [cts_pkg::ID_W-1:0]      w_tw_id;
    logic [cts_pkg::ADDR_W-1:0]    w_tw_data;
    logic                          w_tw_ok;
    logic                          w_enq;
    logic [cts_pkg::ID_W-1:0]      w_enq_id;
    logic                          w_enq_prio;
    logic                          w_ring_we;
    logic [PW-1:0]                 w_ring_waddr;
    logic [cts_pkg::ID_W-1:0]      w_ring_rdata;
    logic [cts_pkg::ID_W-1:0]      w_tbl_raddr;
    logic [cts_pkg::ADDR_W-1:0]    w_tbl_rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_full     = (r_total >= CW'(QUEUE_LENGTH));

    // ring positions; w_dsum and w_nsum stay below twice the ring length, w_psum too while the ring is not full
    assign w_dsum = SW'(r_head) + SW'(QUEUE_LENGTH) - SW'(r_prio);
    assign w_dpos = (w_dsum >= SW'(QUEUE_LENGTH)) ? w_dsum - SW'(QUEUE_LENGTH) : w_dsum;
    assign w_psum = w_dsum - SW'(1);
    assign w_ppos = (w_psum >= SW'(QUEUE_LENGTH)) ? w_psum - SW'(QUEUE_LENGTH) : w_psum;
    assign w_nsum = SW'(r_head) + SW'(r_total - r_prio);
    assign w_npos = (w_nsum >= SW'(QUEUE_LENGTH)) ? w_nsum - SW'(QUEUE_LENGTH) : w_nsum;

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_id    = '0;
        for (int i = cts_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (i < TableSlots && !r_busy[i]) begin
                w_free_found = 1'b1;
                w_free_id    = cts_pkg::ID_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_head     = r_head;
        n_total    = r_total;
        n_prio     = r_prio;
        n_run      = r_run;
        n_o_valid  = r_o_valid && !i_m_tready;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_addr   = r_o_addr;
        w_tw_en    = 1'b0;
        w_tw_id    = '0;
        w_tw_data  = '0;
        w_enq      = 1'b0;
        w_enq_id   = '0;
        w_enq_prio = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_status = cts_pkg::ST_OK;
                    n_o_id     = '0;
                    n_o_addr   = '0;
                    case (r_cmd)
                        cts_pkg::CMD_START: begin
                            if (!w_free_found) begin
                                n_o_status = cts_pkg::ST_TABLE_FULL;
                            end else begin
                                w_tw_en   = 1'b1;
                                w_tw_id   = w_free_id;
                                w_tw_data = r_addr;
                                w_enq     = 1'b1;
                                w_enq_id  = w_free_id;
                                n_o_id    = w_free_id;
                            end
                        end
                        cts_pkg::CMD_SCHEDULE: begin
                            w_enq      = 1'b1;
                            w_enq_id   = r_tid;
                            w_enq_prio = r_preq && r_prio_en;
                        end
                        cts_pkg::CMD_RELINQ: begin
                            w_tw_en   = 1'b1;
                            w_tw_id   = r_run;
                            w_tw_data = r_addr;
                            w_enq     = 1'b1;
                            w_enq_id  = r_run;
                        end
                        cts_pkg::CMD_WAIT: begin
                            w_tw_en   = 1'b1;
                            w_tw_id   = r_run;
                            w_tw_data = r_addr;
                        end
                        cts_pkg::CMD_EXIT: begin
                            w_tw_en   = 1'b1;
                            w_tw_id   = r_run;
                        end
                        cts_pkg::CMD_DISPATCH: begin
                            if (r_total == '0) begin
                                n_o_status = cts_pkg::ST_EMPTY;
                            end else begin
                                // ring word for this pop was read during accept
                                n_o_valid = r_o_valid && !i_m_tready;
                                n_state   = S_TBL;
                                n_run     = w_ring_rdata;
                                n_total   = r_total - CW'(1);
                                if (r_prio != '0) begin
                                    n_prio = r_prio - CW'(1);
                                end else begin
                                    n_head = (int'(r_head) == QUEUE_LENGTH - 1) ?
                                             '0 : r_head + PW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (w_enq) begin
                        if (w_full) begin
                            n_o_status = cts_pkg::ST_QUEUE_FULL;
                        end else begin
                            n_total = r_total + CW'(1);
                            if (w_enq_prio) begin
                                n_prio = r_prio + CW'(1);
                            end
                        end
                    end
                end
            end
            S_TBL: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_status = cts_pkg::ST_OK;
                    n_o_id     = r_run;
                    n_o_addr   = r_busy[r_run] ? w_tbl_rdata : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_tw_ok) begin
            n_busy[w_tw_id] = (w_tw_data != '0);
        end
    end

    assign w_tw_ok      = w_tw_en && (int'(w_tw_id) < TableSlots);
    assign w_ring_we    = w_enq && !w_full;
    assign w_ring_waddr = w_enq_prio ? w_ppos[PW-1:0] : w_npos[PW-1:0];
    assign w_tbl_raddr  = (r_state == S_EXEC) ? w_ring_rdata : r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prio_en <= 1'b1;
            r_busy    <= '0;
            r_head    <= '0;
            r_total   <= '0;
            r_prio    <= '0;
            r_run     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_busy    <= n_busy;
            r_head    <= n_head;
            r_total   <= n_total;
            r_prio    <= n_prio;
            r_run     <= n_run;
            r_o_valid <= n_o_valid;
            if (i_cfg_wen) begin
                r_prio_en <= i_cfg_wdata;
            end
        end
        if (w_acc) begin
            r_cmd  <= i_s_tdata[2:0];
            r_tid  <= i_s_tdata[6:3];
            r_preq <= i_s_tdata[7];
            r_addr <= i_s_tdata[23:8];
        end
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_addr   <= n_o_addr;
    end

    cts_ram #(
        .WIDTH (cts_pkg::ID_W),
        .DEPTH (QUEUE_LENGTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_enq_id),
        .i_raddr (w_dpos[PW-1:0]),
        .o_rdata (w_ring_rdata)
    );

    cts_ram #(
        .WIDTH (cts_pkg::ADDR_W),
        .DEPTH (cts_pkg::NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tw_ok),
        .i_waddr (w_tw_id),
        .i_wdata (w_tw_data),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {2'b00, r_o_addr, r_o_id, r_o_status};

`ifndef SYNTH
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(QUEUE_LENGTH))
        else $error("ready count above ring length");

    a_prio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prio <= r_total)
        else $error("priority count above total count");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_out_free && r_cmd == cts_pkg::CMD_DISPATCH &&
         r_total != '0) |=> (r_total == $past(r_total) - CW'(1)) && (r_state == S_TBL))
        else $error("dispatch did not pop one entry");
`endif

endmodule
